[src/lbps_pkg.sv]
// ----------------------------------------------------------------------------
// lbps_pkg
// Shared types, constants and pattern tables for the LED blink sequencer.
// ----------------------------------------------------------------------------
package lbps_pkg;

  // sizing
  localparam int MaxSteps  = 6;
  localparam int TimeWidth = 32;
  localparam int StepW     = (MaxSteps > 2) ? $clog2(MaxSteps) : 1;
  localparam int LenW      = $clog2(MaxSteps + 1);
  localparam int NumModes  = 8;
  localparam int RomSteps  = 8;

  typedef logic [TimeWidth-1:0] time_t;
  typedef logic [StepW-1:0]     step_t;
  typedef logic [LenW-1:0]      len_t;
  typedef logic [15:0]          dwell_t;

  // operation codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MODE = 1'b1
  } op_e;

  // input beat
  typedef struct packed {
    logic        operation;
    logic [31:0] now;
    logic [2:0]  mode;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic led_on;
    logic pin_level;
  } out_item_t;

  // dwell times in ms, one row per mode
  localparam dwell_t DwellRom [NumModes][RomSteps] = '{
    '{16'd60,   16'd2400, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0, 16'd0},
    '{16'd120,  16'd120,  16'd120, 16'd120, 16'd120, 16'd600, 16'd0, 16'd0},
    '{16'd450,  16'd450,  16'd0,   16'd0,   16'd0,   16'd0,   16'd0, 16'd0},
    '{16'd140,  16'd140,  16'd0,   16'd0,   16'd0,   16'd0,   16'd0, 16'd0},
    '{16'd110,  16'd110,  16'd110, 16'd520, 16'd0,   16'd0,   16'd0, 16'd0},
    '{16'd1600, 16'd180,  16'd0,   16'd0,   16'd0,   16'd0,   16'd0, 16'd0},
    '{16'd90,   16'd90,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0, 16'd0},
    '{16'd130,  16'd130,  16'd130, 16'd760, 16'd0,   16'd0,   16'd0, 16'd0}
  };

  // pattern lengths before clamping
  localparam logic [3:0] LengthRom [NumModes] = '{
    4'd2, 4'd6, 4'd2, 4'd2, 4'd4, 4'd2, 4'd2, 4'd4
  };

  // effective pattern length, clamped to the step budget
  function automatic len_t pattern_len(input logic [2:0] sel);
    logic [3:0] n;
    begin
      n = LengthRom[sel];
      if (int'(n) > MaxSteps) begin
        n = 4'(MaxSteps);
      end
      if (n == 4'd0) begin
        n = 4'd1;
      end
      return LenW'(n);
    end
  endfunction

  // dwell for a pattern step
  function automatic dwell_t dwell_of(input logic [2:0] sel, input step_t idx);
    logic [2:0] col;
    begin
      col = 3'(idx);
      return DwellRom[sel][col];
    end
  endfunction

endpackage

[src/led_blink_pattern_sequencer.sv]
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer
// Steps one status LED through fixed per-mode blink patterns.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one beat per
//   event: a mode change (selects pattern, restarts it, lights the LED) or a
//   time tick carrying the current millisecond count.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns one beat
//   per input beat with the logical LED state and the pin level.
//   cfg_we_i / cfg_data_i write the active_low polarity bit; write it only
//   while no beat is in flight.
//   An accepted input beat is loaded into the input register; when the result
//   register is free or not stalled, the dwell compare and step update run
//   into the result register. One beat per cycle is sustained while the output
//   is not stalled; the single subtract-and-compare against the dwell table
//   bounds the clock.
//   Reset selects the idle pattern at step 0 with the LED lit, clears the
//   time stamp and sets active_low to 0. Both pipeline registers empty.
//   A stall on the output holds the result; the input register keeps one more
//   beat, after which in_stall_o rises.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lbps_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lbps_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i
);

  logic                active_low_q;
  logic                in_valid_q;
  lbps_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  lbps_pkg::out_item_t out_item_q;
  lbps_pkg::out_item_t out_item_d;

  logic [2:0]          pat_q, pat_d;
  lbps_pkg::step_t     step_q, step_d;
  lbps_pkg::time_t     last_q, last_d;
  logic                lit_q, lit_d;

  logic                advance;
  logic                in_take;
  lbps_pkg::time_t     now_ext;
  lbps_pkg::time_t     elapsed;
  lbps_pkg::len_t      cur_len;
  lbps_pkg::step_t     step_inc;

  // pipeline handshake
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= 1'b0;
    end else if (cfg_we_i) begin
      active_low_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_data_i;
    end
  end

  // step update: elapsed time against the current dwell
  assign now_ext  = lbps_pkg::TimeWidth'(in_item_q.now);
  assign elapsed  = now_ext - last_q;
  assign cur_len  = lbps_pkg::pattern_len(pat_q);
  assign step_inc = (lbps_pkg::LenW'(step_q) + lbps_pkg::LenW'(1) == cur_len) ?
                    '0 : step_q + lbps_pkg::StepW'(1);

  always_comb begin
    pat_d  = pat_q;
    step_d = step_q;
    last_d = last_q;
    lit_d  = lit_q;
    if (lbps_pkg::op_e'(in_item_q.operation) == lbps_pkg::OP_MODE) begin
      pat_d  = in_item_q.mode;
      step_d = '0;
      last_d = now_ext;
      lit_d  = 1'b1;
    end else if (elapsed >=
                 lbps_pkg::TimeWidth'(lbps_pkg::dwell_of(pat_q, step_q))) begin
      step_d = step_inc;
      last_d = now_ext;
      lit_d  = ~step_inc[0];
    end
    out_item_d.led_on    = lit_d;
    out_item_d.pin_level = lit_d ^ active_low_q;
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      step_q <= '0;
      last_q <= '0;
      lit_q  <= 1'b1;
    end else if (advance) begin
      pat_q  <= pat_d;
      step_q <= step_d;
      last_q <= last_d;
      lit_q  <= lit_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  // checks

  // step index stays inside the selected pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lbps_pkg::LenW'(step_q) < lbps_pkg::pattern_len(pat_q))
    else $error("step index beyond pattern length");

  // LED is lit exactly on even steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_q == ~step_q[0])
    else $error("LED state out of step with index");

  // input stall only with a held beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  // a stalled result is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_item_q))
    else $error("stalled result lost or changed");

  // a beat taken while the output is free reaches the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("held beat did not advance");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for led_blink_pattern_sequencer. A clocked driver feeds
// input beats from a queue of pending items, a clocked monitor compares every
// result beat with a prediction made when its input beat was accepted. The
// run mixes directed beats with random mode/tick sequences under several
// polarity settings, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit  = 200_000;
  localparam int StepBudget  = lbps_pkg::MaxSteps;
  localparam int RandomBeats = 300;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_STARTING = 3'd1,
    MODE_THINKING = 3'd2,
    MODE_CODING   = 3'd3,
    MODE_TESTING  = 3'd4,
    MODE_DONE     = 3'd5,
    MODE_ERROR    = 3'd6,
    MODE_MESSAGE  = 3'd7
  } led_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  lbps_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  lbps_pkg::out_item_t out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_data_i  = 1'b0;

  // beats waiting to be driven, results predicted but not yet seen
  lbps_pkg::in_item_t  pending_beats[$];
  lbps_pkg::out_item_t predicted_leds[$];

  // predictor copy of the sequencer state
  logic [2:0]      led_pattern = MODE_IDLE;
  int unsigned     led_step    = 0;
  lbps_pkg::time_t led_stamp   = '0;
  logic            led_lit     = 1'b1;
  logic            led_pol     = 1'b0;

  int unsigned     idle_pct     = 15;
  int unsigned     cycle_count  = 0;
  int unsigned     beats_sent   = 0;
  int unsigned     leds_checked = 0;
  int unsigned     mode_count   = 0;
  int unsigned     toggle_count = 0;
  int unsigned     error_count  = 0;
  lbps_pkg::time_t gen_now      = '0;

  led_blink_pattern_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // dwell in ms for one step of a pattern
  function automatic int unsigned dwell_ms(input logic [2:0] pat, input int unsigned idx);
    int unsigned d;
    d = 0;
    case (pat)
      MODE_IDLE:     d = (idx == 0) ? 60 : 2400;
      MODE_STARTING: d = (idx == 5) ? 600 : 120;
      MODE_THINKING: d = 450;
      MODE_CODING:   d = 140;
      MODE_TESTING:  d = (idx == 3) ? 520 : 110;
      MODE_DONE:     d = (idx == 0) ? 1600 : 180;
      MODE_ERROR:    d = 90;
      default:       d = (idx == 3) ? 760 : 130;
    endcase
    return d;
  endfunction

  // steps per pattern, clipped to the step budget
  function automatic int unsigned pattern_steps(input logic [2:0] pat);
    int unsigned n;
    case (pat)
      MODE_STARTING:              n = 6;
      MODE_TESTING, MODE_MESSAGE: n = 4;
      default:                    n = 2;
    endcase
    if (n > StepBudget) begin
      n = StepBudget;
    end
    if (n < 1) begin
      n = 1;
    end
    return n;
  endfunction

  // advance the predicted state by one beat and return the led result
  function automatic lbps_pkg::out_item_t predict_led(input lbps_pkg::in_item_t beat);
    int unsigned         len;
    int unsigned         idx;
    lbps_pkg::time_t     elapsed;
    lbps_pkg::out_item_t res;
    if (beat.operation == lbps_pkg::OP_MODE) begin
      led_pattern = beat.mode;
      led_step    = 0;
      led_stamp   = beat.now;
      led_lit     = 1'b1;
      mode_count++;
    end else begin
      len     = pattern_steps(led_pattern);
      idx     = led_step % len;
      elapsed = beat.now - led_stamp;
      if (elapsed >= dwell_ms(led_pattern, idx)) begin
        idx       = (idx + 1) % len;
        led_step  = idx;
        led_stamp = beat.now;
        led_lit   = (idx % 2 == 0);
        toggle_count++;
      end
    end
    res.led_on    = led_lit;
    res.pin_level = led_lit ^ led_pol;
    return res;
  endfunction

  // input driver: count accepted beats, present the next one or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted_leds.push_back(predict_led(in_data_i));
        beats_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_beats.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data_i  <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor: random stall, compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    lbps_pkg::out_item_t want;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(0, 99) < idle_pct);
      if (out_valid_o && !out_stall_i) begin
        if (predicted_leds.size() == 0) begin
          $display("%0t: result beat with nothing predicted: led_on %0b pin_level %0b",
                   $realtime, out_data_o.led_on, out_data_o.pin_level);
          error_count++;
        end else begin
          want = predicted_leds.pop_front();
          if (out_data_o.led_on !== want.led_on) begin
            $display("%0t: led_on mismatch: expected %0b actual %0b",
                     $realtime, want.led_on, out_data_o.led_on);
            error_count++;
          end
          if (out_data_o.pin_level !== want.pin_level) begin
            $display("%0t: pin_level mismatch: expected %0b actual %0b",
                     $realtime, want.pin_level, out_data_o.pin_level);
            error_count++;
          end
          leds_checked++;
        end
      end
    end
  end

  // hang guard
  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, predicted_leds.size());
    $display("led_blink_pattern_sequencer verification failed");
    $finish;
  end

  task automatic push_beat(input logic op, input lbps_pkg::time_t now,
                           input logic [2:0] mode);
    lbps_pkg::in_item_t beat;
    beat.operation = op;
    beat.now       = now;
    beat.mode      = mode;
    pending_beats.push_back(beat);
  endtask

  // hold the sender until every pending beat has produced its result
  task automatic drain_beats();
    while (pending_beats.size() > 0 || in_valid_i || predicted_leds.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_polarity(input logic value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    led_pol = value;
  endtask

  // mostly realistic sessions: mode change, then ticks walking forward in time
  task automatic queue_random_beats(input int count);
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_beat(lbps_pkg::OP_MODE, gen_now, 3'($urandom_range(0, 7)));
      end else begin
        if (pick < 50) begin
          gen_now = gen_now + $urandom_range(0, 60);
        end else if (pick < 80) begin
          gen_now = gen_now + $urandom_range(60, 200);
        end else if (pick < 92) begin
          gen_now = gen_now + $urandom_range(200, 2500);
        end else if (pick < 95) begin
          gen_now = gen_now + $urandom_range(0, 1);
        end else if (pick < 97) begin
          // time stepping backwards, elapsed wraps to huge
          gen_now = gen_now - $urandom_range(1, 50);
        end else begin
          gen_now = $urandom;
        end
        push_beat(lbps_pkg::OP_TICK, gen_now, 3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_polarity(1'b0);

    // directed: idle pattern from reset, dwell edges, wrapping time, every mode
    push_beat(lbps_pkg::OP_TICK, 32'd0,    MODE_IDLE);
    push_beat(lbps_pkg::OP_TICK, 32'd59,   MODE_IDLE);
    push_beat(lbps_pkg::OP_TICK, 32'd60,   MODE_IDLE);
    push_beat(lbps_pkg::OP_TICK, 32'd2459, MODE_IDLE);
    push_beat(lbps_pkg::OP_TICK, 32'd2460, MODE_IDLE);
    push_beat(lbps_pkg::OP_MODE, 32'hFFFF_FF00, MODE_THINKING);
    push_beat(lbps_pkg::OP_TICK, 32'hFFFF_FFFF, MODE_MESSAGE);
    push_beat(lbps_pkg::OP_TICK, 32'h0000_00C1, MODE_MESSAGE);
    push_beat(lbps_pkg::OP_TICK, 32'h0000_00C2, MODE_IDLE);
    push_beat(lbps_pkg::OP_MODE, 32'hFFFF_FFFF, MODE_STARTING);
    push_beat(lbps_pkg::OP_TICK, 32'h0000_0076, MODE_IDLE);
    push_beat(lbps_pkg::OP_TICK, 32'h0000_0077, MODE_IDLE);
    push_beat(lbps_pkg::OP_MODE, 32'd0, MODE_MESSAGE);
    push_beat(lbps_pkg::OP_TICK, 32'hFFFF_FFFF, MODE_MESSAGE);
    push_beat(lbps_pkg::OP_MODE, 32'h5555_5555, MODE_CODING);
    push_beat(lbps_pkg::OP_TICK, 32'hAAAA_AAAA, MODE_IDLE);
    push_beat(lbps_pkg::OP_MODE, 32'hAAAA_AAAA, MODE_TESTING);
    push_beat(lbps_pkg::OP_TICK, 32'hAAAA_AB18, MODE_TESTING);
    push_beat(lbps_pkg::OP_MODE, 32'd100,  MODE_DONE);
    push_beat(lbps_pkg::OP_TICK, 32'd1700, MODE_DONE);
    push_beat(lbps_pkg::OP_MODE, 32'd7,    MODE_ERROR);
    push_beat(lbps_pkg::OP_TICK, 32'd96,   MODE_ERROR);
    push_beat(lbps_pkg::OP_TICK, 32'd97,   MODE_ERROR);
    push_beat(lbps_pkg::OP_MODE, 32'h8000_0000, MODE_IDLE);
    push_beat(lbps_pkg::OP_TICK, 32'h8000_003C, MODE_IDLE);
    drain_beats();

    // random sessions under both polarities, one phase without idling
    gen_now = $urandom;
    write_polarity(1'b1);
    queue_random_beats(RandomBeats);
    drain_beats();

    idle_pct = 0;
    write_polarity(1'b0);
    queue_random_beats(RandomBeats);
    drain_beats();

    idle_pct = 15;
    write_polarity(1'b1);
    queue_random_beats(RandomBeats);
    drain_beats();

    // catch any stray result beats
    repeat (10) @(posedge clk_i);
    if (predicted_leds.size() > 0) begin
      $display("%0t: %0d predicted results never arrived", $realtime, predicted_leds.size());
      error_count++;
    end

    $display("covered %0d input beats (%0d mode changes, %0d led toggles), %0d results checked",
             beats_sent, mode_count, toggle_count, leds_checked);
    $display("polarity exercised at both settings, %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("led_blink_pattern_sequencer verification clean");
    end else begin
      $display("led_blink_pattern_sequencer verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/lbps_pkg.sv
src/led_blink_pattern_sequencer.sv
sim/testbench.sv
